### hw/rtl/hcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcp_pkg;

    // configured matrix size, one register per axis
    typedef logic [10:0] t_dim;

    // one signed step of -1, 0 or +1
    typedef logic signed [1:0] t_off;

    // register indexes on the config port
    localparam logic [1:0] REG_DIM_X = 2'd0;
    localparam logic [1:0] REG_DIM_Y = 2'd1;
    localparam logic [1:0] REG_DIM_Z = 2'd2;

    localparam t_dim DIM_RESET = 11'd1024;

    // valid neighbor numbers are below this
    localparam logic [3:0] NBR_COUNT = 4'd12;

    // width of an output coordinate
    localparam int OUT_BITS = 12;

    // x offsets, row index {z odd, y odd}, column is the neighbor number;
    // numbers twelve and up map to a zero step
    localparam t_off OFF_X [4][16] = '{
        '{ 2'sd0,  2'sd0, -2'sd1,  2'sd0,  2'sd1,  2'sd0, -2'sd1, -2'sd1,
          -2'sd1,  2'sd0,  2'sd0, -2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0 },
        '{ 2'sd1,  2'sd0,  2'sd0,  2'sd1,  2'sd1,  2'sd1,  2'sd0, -2'sd1,
           2'sd0,  2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd0 },
        '{ 2'sd0,  2'sd0,  2'sd1,  2'sd1,  2'sd1,  2'sd1,  2'sd0, -2'sd1,
           2'sd0,  2'sd0,  2'sd0,  2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0 },
        '{-2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd1,  2'sd0, -2'sd1, -2'sd1,
          -2'sd1, -2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd0 }
    };

    // y offsets depend only on z parity
    localparam t_off OFF_Y [2][16] = '{
        '{ 2'sd0, -2'sd1,  2'sd0,  2'sd1,  2'sd0, -2'sd1, -2'sd1,  2'sd0,
           2'sd1,  2'sd0, -2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd0 },
        '{ 2'sd0,  2'sd1,  2'sd0,  2'sd1,  2'sd0, -2'sd1, -2'sd1,  2'sd0,
           2'sd1,  2'sd0,  2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd0 }
    };

    // layer above, same layer, layer below
    localparam t_off OFF_Z [16] = '{
         2'sd1,  2'sd1,  2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd0,
         2'sd0, -2'sd1, -2'sd1, -2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0
    };

endpackage

`default_nettype wire

### hw/rtl/hcp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// query channel: centre cell and neighbor number
interface hcp_in_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_y;
    logic [COORD_BITS-1:0] cell_z;
    logic [3:0]            neighbor_num;

    modport source (
        output valid, cell_x, cell_y, cell_z, neighbor_num,
        input  ready
    );

    modport sink (
        input  valid, cell_x, cell_y, cell_z, neighbor_num,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/hcp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// result channel: neighbor coordinate and bounds flag
interface hcp_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [11:0]       nbr_x;
    logic signed [11:0]       nbr_y;
    logic signed [11:0]       nbr_z;
    logic                     in_bounds;

    modport source (
        output valid, nbr_x, nbr_y, nbr_z, in_bounds,
        input  ready
    );

    modport sink (
        input  valid, nbr_x, nbr_y, nbr_z, in_bounds,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/hcp_neighbor_coordinate_calc_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel    | dir | modport | word
// -----------+-----+---------+------------------------------------------
// i_req      | in  | sink    | cell_x, cell_y, cell_z, neighbor_num
// o_rsp      | out | source  | nbr_x, nbr_y, nbr_z, in_bounds
// apb        | in  | slave   | dim_x @0x0, dim_y @0x4, dim_z @0x8
//
// two register stages: query register, then result register; o_rsp.valid
// rises as the result register loads; one word a cycle unless o_rsp stalls.
// the offset table lookup, three adds and the bounds compares sit between
// the two registers. i_rst_n is synchronous and clears the stage valids and
// restores every dimension to 1024. a stall on o_rsp holds the result
// register and backs up into the query register, then into i_req.ready.
module hcp_neighbor_coordinate_calc_unit #(
    parameter int COORD_BITS = 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    hcp_in_if.sink               i_req,
    hcp_out_if.source            o_rsp,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [3:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    output logic                 pready
);

    // internal signed width: holds -1 .. 2^COORD_BITS and the dim limits
    localparam int W = (COORD_BITS + 2 > 13) ? COORD_BITS + 2 : 13;
    localparam int OB = hcp_pkg::OUT_BITS;

    // config registers
    hcp_pkg::t_dim r_dim_x;
    hcp_pkg::t_dim r_dim_y;
    hcp_pkg::t_dim r_dim_z;

    // query stage
    logic                  r_s1_valid;
    logic [COORD_BITS-1:0] r_cell_x;
    logic [COORD_BITS-1:0] r_cell_y;
    logic [COORD_BITS-1:0] r_cell_z;
    logic [3:0]            r_nbr_num;

    // result stage
    logic                  r_s2_valid;
    logic signed [OB-1:0]  r_nbr_x;
    logic signed [OB-1:0]  r_nbr_y;
    logic signed [OB-1:0]  r_nbr_z;
    logic                  r_in_bounds;

    logic                  w_adv2;
    logic                  w_adv1;
    logic                  w_cfg_wr;
    logic [1:0]            w_cfg_idx;

    hcp_pkg::t_off         w_off_x;
    hcp_pkg::t_off         w_off_y;
    hcp_pkg::t_off         w_off_z;
    logic signed [W-1:0]   w_nx;
    logic signed [W-1:0]   w_ny;
    logic signed [W-1:0]   w_nz;
    logic signed [W-1:0]   w_dx;
    logic signed [W-1:0]   w_dy;
    logic signed [W-1:0]   w_dz;
    logic signed [W-1:0]   w_lim_x;
    logic signed [W-1:0]   w_lim_y;
    logic                  w_in_bounds;

    // apb config port, no wait states
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= hcp_pkg::DIM_RESET;
            r_dim_y <= hcp_pkg::DIM_RESET;
            r_dim_z <= hcp_pkg::DIM_RESET;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                hcp_pkg::REG_DIM_X: r_dim_x <= pwdata[10:0];
                hcp_pkg::REG_DIM_Y: r_dim_y <= pwdata[10:0];
                hcp_pkg::REG_DIM_Z: r_dim_z <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_cfg_idx)
            hcp_pkg::REG_DIM_X: prdata = {21'd0, r_dim_x};
            hcp_pkg::REG_DIM_Y: prdata = {21'd0, r_dim_y};
            hcp_pkg::REG_DIM_Z: prdata = {21'd0, r_dim_z};
            default:            prdata = 32'd0;
        endcase
    end

    // pipeline flow control
    assign w_adv2      = !r_s2_valid || o_rsp.ready;
    assign w_adv1      = !r_s1_valid || w_adv2;
    assign i_req.ready = w_adv1;

    // query register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv1) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_req.valid) begin
            r_cell_x  <= i_req.cell_x;
            r_cell_y  <= i_req.cell_y;
            r_cell_z  <= i_req.cell_z;
            r_nbr_num <= i_req.neighbor_num;
        end
    end

    // offset lookup by parity of the centre cell
    assign w_off_x = hcp_pkg::OFF_X[{r_cell_z[0], r_cell_y[0]}][r_nbr_num];
    assign w_off_y = hcp_pkg::OFF_Y[r_cell_z[0]][r_nbr_num];
    assign w_off_z = hcp_pkg::OFF_Z[r_nbr_num];

    // neighbor coordinate
    assign w_nx = $signed({{(W-COORD_BITS){1'b0}}, r_cell_x})
                + $signed({{(W-2){w_off_x[1]}}, w_off_x});
    assign w_ny = $signed({{(W-COORD_BITS){1'b0}}, r_cell_y})
                + $signed({{(W-2){w_off_y[1]}}, w_off_y});
    assign w_nz = $signed({{(W-COORD_BITS){1'b0}}, r_cell_z})
                + $signed({{(W-2){w_off_z[1]}}, w_off_z});

    // limits: staggered rows lose one x cell, odd layers lose one y row
    assign w_dx    = $signed({{(W-11){1'b0}}, r_dim_x});
    assign w_dy    = $signed({{(W-11){1'b0}}, r_dim_y});
    assign w_dz    = $signed({{(W-11){1'b0}}, r_dim_z});
    assign w_lim_x = (w_nz[0] != w_ny[0]) ? w_dx - W'(2) : w_dx - W'(1);
    assign w_lim_y = w_nz[0] ? w_dy - W'(2) : w_dy - W'(1);

    // bounds check
    assign w_in_bounds = (r_nbr_num < hcp_pkg::NBR_COUNT)
                      && !w_nz[W-1] && (w_nz < w_dz)
                      && !w_ny[W-1] && (w_ny <= w_lim_y)
                      && !w_nx[W-1] && (w_nx <= w_lim_x);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_s1_valid) begin
            r_nbr_x     <= w_nx[OB-1:0];
            r_nbr_y     <= w_ny[OB-1:0];
            r_nbr_z     <= w_nz[OB-1:0];
            r_in_bounds <= w_in_bounds;
        end
    end

    assign o_rsp.valid     = r_s2_valid;
    assign o_rsp.nbr_x     = r_nbr_x;
    assign o_rsp.nbr_y     = r_nbr_y;
    assign o_rsp.nbr_z     = r_nbr_z;
    assign o_rsp.in_bounds = r_in_bounds;

`ifndef SYNTHESIS
    // a dim_x write lands in the register
    a_cfg_dim_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && (w_cfg_idx == hcp_pkg::REG_DIM_X))
        |=> (r_dim_x == $past(pwdata[10:0])))
        else $error("dim_x write not taken");

    // an in-bounds neighbor never has a negative coordinate
    a_bounds_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_in_bounds)
        |-> (!r_nbr_x[OB-1] && !r_nbr_y[OB-1] && !r_nbr_z[OB-1]))
        else $error("in-bounds result with negative coordinate");

    // an unknown neighbor number always gives an out-of-bounds result
    a_bad_nbr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_adv2 && (r_nbr_num >= hcp_pkg::NBR_COUNT))
        |=> (r_s2_valid && !r_in_bounds))
        else $error("bad neighbor number reported in bounds");
`endif

endmodule

`default_nettype wire
